@@ sv/q16a_pkg.sv @@
`default_nettype none

package q16a_pkg;

  localparam int WORD_W         = 32;
  localparam int Q16A_FRAC_BITS = 16;

  localparam logic [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic [2:0] {
    MODE_ADD      = 3'd0,
    MODE_SUB      = 3'd1,
    MODE_MUL_SAT  = 3'd2,
    MODE_MUL_WRAP = 3'd3,
    MODE_DIV      = 3'd4
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic [WORD_W-1:0] res;
    logic              neg;
    logic              bzero;
  } aux_t;

  function automatic logic [WORD_W-1:0] sat_wide(input logic [WORD_W:0] v);
    logic [WORD_W-1:0] r;
    if (v[WORD_W] != v[WORD_W-1]) begin
      r = v[WORD_W] ? SAT_MIN : SAT_MAX;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/q16a_mul.sv @@
`default_nettype none

module q16a_mul #(
  parameter int FRAC_BITS = q16a_pkg::Q16A_FRAC_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic signed [q16a_pkg::WORD_W-1:0] a,
  input  wire logic signed [q16a_pkg::WORD_W-1:0] b,
  output logic             [q16a_pkg::WORD_W-1:0] sat_r,
  output logic             [q16a_pkg::WORD_W-1:0] wrap_r
);
  import q16a_pkg::*;

  localparam int PW = 2 * WORD_W;

  logic signed [PW-1:0] product_r;
  logic signed [PW-1:0] shifted;
  logic                 in_range;
  logic [WORD_W-1:0]    sat_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      product_r <= a * b;
    end
  end

  always_comb begin
    shifted  = product_r >>> FRAC_BITS;
    in_range = (&shifted[PW-1:WORD_W-1]) || !(|shifted[PW-1:WORD_W-1]);
    if (in_range) begin
      sat_nxt = shifted[WORD_W-1:0];
    end else begin
      sat_nxt = shifted[PW-1] ? SAT_MIN : SAT_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r  <= sat_nxt;
      wrap_r <= shifted[WORD_W-1:0];
    end
  end

endmodule

`default_nettype wire

@@ sv/q16a_div.sv @@
`default_nettype none

module q16a_div #(
  parameter int FRAC_BITS = q16a_pkg::Q16A_FRAC_BITS
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      en,
  input  wire logic                                      in_v,
  input  wire logic [q16a_pkg::WORD_W-1:0]               in_dividend,
  input  wire logic [q16a_pkg::WORD_W-1:0]               in_divisor,
  input  wire q16a_pkg::aux_t                            in_aux,
  output logic                                           out_v,
  output logic [q16a_pkg::WORD_W+FRAC_BITS-1:0]          out_quo,
  output q16a_pkg::aux_t                                 out_aux
);
  import q16a_pkg::*;

  localparam int QW = WORD_W + FRAC_BITS;

  logic              v_r    [QW];
  logic [WORD_W-1:0] rem_r  [QW];
  logic [QW-1:0]     dq_r   [QW];
  logic [WORD_W-1:0] dsor_r [QW];
  aux_t              aux_r  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic              src_v;
    logic [WORD_W-1:0] src_rem;
    logic [QW-1:0]     src_dq;
    logic [WORD_W-1:0] src_dsor;
    aux_t              src_aux;
    logic [WORD_W:0]   trial;
    logic [WORD_W+1:0] diff;
    logic              ge;
    logic [WORD_W-1:0] rem_nxt;
    logic [QW-1:0]     dq_nxt;

    if (i == 0) begin : g_first
      assign src_v    = in_v;
      assign src_rem  = '0;
      assign src_dq   = {in_dividend, {FRAC_BITS{1'b0}}};
      assign src_dsor = in_divisor;
      assign src_aux  = in_aux;
    end else begin : g_next
      assign src_v    = v_r[i-1];
      assign src_rem  = rem_r[i-1];
      assign src_dq   = dq_r[i-1];
      assign src_dsor = dsor_r[i-1];
      assign src_aux  = aux_r[i-1];
    end

    always_comb begin
      trial   = {src_rem, src_dq[QW-1]};
      diff    = {1'b0, trial} - {2'b00, src_dsor};
      ge      = !diff[WORD_W+1];
      rem_nxt = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
      dq_nxt  = {src_dq[QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        dq_r[i]   <= dq_nxt;
        dsor_r[i] <= src_dsor;
        aux_r[i]  <= src_aux;
      end
    end
  end

  assign out_v   = v_r[QW-1];
  assign out_quo = dq_r[QW-1];
  assign out_aux = aux_r[QW-1];

endmodule

`default_nettype wire

@@ sv/q16_16_fixed_point_alu.sv @@
`default_nettype none

// Signed fixed-point ALU with FRAC_BITS fraction bits: saturating add and subtract,
// saturating and wrapping multiply, and saturating divide (zero divisor gives 0).
// Unused mode codes give 0. It takes one transfer every cycle while the result side does
// not stall. The divider resolves one quotient bit per stage over 32 + FRAC_BITS
// stages, with every mode passing through the same stages to keep order.
// A stall on the result side holds the whole pipeline.
module q16_16_fixed_point_alu #(
  parameter int FRAC_BITS = q16a_pkg::Q16A_FRAC_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [2:0]                          in_mode,
  input  wire logic signed [q16a_pkg::WORD_W-1:0]  in_operand_a,
  input  wire logic signed [q16a_pkg::WORD_W-1:0]  in_operand_b,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [q16a_pkg::WORD_W-1:0]       out_result
);
  import q16a_pkg::*;

  localparam int QW = WORD_W + FRAC_BITS;

  logic en;

  logic                     v0_r;
  mode_t                    mode0_r;
  logic signed [WORD_W-1:0] a0_r;
  logic signed [WORD_W-1:0] b0_r;

  logic [WORD_W:0]   sum;
  logic [WORD_W:0]   dif;
  logic [WORD_W-1:0] addsub_nxt;
  logic [WORD_W-1:0] absa_nxt;
  logic [WORD_W-1:0] absb_nxt;

  logic              v1_r;
  mode_t             mode1_r;
  logic [WORD_W-1:0] addsub1_r;
  logic [WORD_W-1:0] absa1_r;
  logic [WORD_W-1:0] absb1_r;
  logic              neg1_r;
  logic              bzero1_r;

  logic              v2_r;
  mode_t             mode2_r;
  logic [WORD_W-1:0] addsub2_r;
  logic [WORD_W-1:0] absa2_r;
  logic [WORD_W-1:0] absb2_r;
  logic              neg2_r;
  logic              bzero2_r;

  logic [WORD_W-1:0] mul_sat;
  logic [WORD_W-1:0] mul_wrap;
  logic [WORD_W-1:0] nondiv;
  aux_t              aux2;

  logic              dv;
  logic [QW-1:0]     dq;
  aux_t              daux;
  logic              ovf_pos;
  logic              ovf_neg;
  logic [WORD_W-1:0] res_nxt;

  logic              out_valid_r;
  logic [WORD_W-1:0] out_result_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode0_r <= mode_t'(in_mode);
      a0_r    <= in_operand_a;
      b0_r    <= in_operand_b;
    end
  end

  always_comb begin
    sum      = {a0_r[WORD_W-1], a0_r} + {b0_r[WORD_W-1], b0_r};
    dif      = {a0_r[WORD_W-1], a0_r} - {b0_r[WORD_W-1], b0_r};
    addsub_nxt = (mode0_r == MODE_SUB) ? sat_wide(dif) : sat_wide(sum);
    absa_nxt = a0_r[WORD_W-1] ? (~a0_r + 1'b1) : a0_r;
    absb_nxt = b0_r[WORD_W-1] ? (~b0_r + 1'b1) : b0_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mode1_r   <= mode0_r;
      addsub1_r <= addsub_nxt;
      absa1_r   <= absa_nxt;
      absb1_r   <= absb_nxt;
      neg1_r    <= a0_r[WORD_W-1] ^ b0_r[WORD_W-1];
      bzero1_r  <= (b0_r == '0);
      mode2_r   <= mode1_r;
      addsub2_r <= addsub1_r;
      absa2_r   <= absa1_r;
      absb2_r   <= absb1_r;
      neg2_r    <= neg1_r;
      bzero2_r  <= bzero1_r;
    end
  end

  q16a_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .en    (en),
    .a     (a0_r),
    .b     (b0_r),
    .sat_r (mul_sat),
    .wrap_r(mul_wrap)
  );

  always_comb begin
    case (mode2_r)
      MODE_ADD, MODE_SUB: nondiv = addsub2_r;
      MODE_MUL_SAT:       nondiv = mul_sat;
      MODE_MUL_WRAP:      nondiv = mul_wrap;
      default:            nondiv = '0;
    endcase
    aux2.mode  = mode2_r;
    aux2.res   = nondiv;
    aux2.neg   = neg2_r;
    aux2.bzero = bzero2_r;
  end

  q16a_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_v       (v2_r),
    .in_dividend(absa2_r),
    .in_divisor (absb2_r),
    .in_aux     (aux2),
    .out_v      (dv),
    .out_quo    (dq),
    .out_aux    (daux)
  );

  always_comb begin
    ovf_pos = |dq[QW-1:WORD_W-1];
    ovf_neg = (|dq[QW-1:WORD_W]) || (dq[WORD_W-1] && (|dq[WORD_W-2:0]));
    case (daux.mode)
      MODE_DIV: begin
        if (daux.bzero) begin
          res_nxt = '0;
        end else if (daux.neg) begin
          res_nxt = ovf_neg ? SAT_MIN : (~dq[WORD_W-1:0] + 1'b1);
        end else begin
          res_nxt = ovf_pos ? SAT_MAX : dq[WORD_W-1:0];
        end
      end
      default: res_nxt = daux.res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_result_r <= res_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

`default_nettype wire

@@ sv/q16a_checker.sv @@
`default_nettype none

module q16a_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_stall,
  input wire logic                               out_valid,
  input wire logic                               out_stall,
  input wire logic [q16a_pkg::WORD_W-1:0]        out_result
);

  // The pipeline moves as one, so the input side stalls exactly when a result waits.
  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the waiting result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_result))
    else $error("stalled result changed");

endmodule

bind q16_16_fixed_point_alu q16a_checker u_q16a_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_result(out_result)
);

`default_nettype wire

@@ sim/q16a_result_checker.sv @@
`timescale 1ns / 1ps

module q16a_result_checker
  import q16a_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [2:0]               in_mode,
  input  logic signed [WORD_W-1:0] in_operand_a,
  input  logic signed [WORD_W-1:0] in_operand_b,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [WORD_W-1:0] out_result,
  output int                       error_count,
  output int                       pending_count,
  output int                       checked_count
);

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  logic signed [WORD_W-1:0] pending_results[$];

  function automatic longint clamp_word(input longint v);
    longint r;
    if (v > WORD_MAX) begin
      r = WORD_MAX;
    end else if (v < WORD_MIN) begin
      r = WORD_MIN;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic signed [WORD_W-1:0] fixed_point_result(
    input logic [2:0]               mode,
    input logic signed [WORD_W-1:0] a,
    input logic signed [WORD_W-1:0] b
  );
    longint sa;
    longint sb;
    longint r;
    sa = a;
    sb = b;
    r = 0;
    case (mode)
      MODE_ADD: begin
        r = clamp_word(sa + sb);
      end
      MODE_SUB: begin
        r = clamp_word(sa - sb);
      end
      MODE_MUL_SAT: begin
        r = clamp_word((sa * sb) >>> Q16A_FRAC_BITS);
      end
      MODE_MUL_WRAP: begin
        r = (sa * sb) >>> Q16A_FRAC_BITS;
      end
      MODE_DIV: begin
        if (sb != 0) begin
          r = clamp_word((sa <<< Q16A_FRAC_BITS) / sb);
        end
      end
      default: begin
        r = 0;
      end
    endcase
    return r[WORD_W-1:0];
  endfunction

  always @(posedge clk) begin
    logic signed [WORD_W-1:0] want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected: result 0x%08h", out_result);
          error_count <= error_count + 1;
        end else begin
          want = pending_results.pop_front();
          if (out_result !== want) begin
            $error("result mismatch: expected %0d (0x%08h), actual %0d (0x%08h)",
                   want, want, out_result, out_result);
            error_count <= error_count + 1;
          end
          checked_count <= checked_count + 1;
        end
      end
      if (in_valid && !in_stall) begin
        pending_results.push_back(fixed_point_result(in_mode, in_operand_a, in_operand_b));
      end
      pending_count <= pending_results.size();
    end
  end

endmodule

@@ sim/tb_q16_16_fixed_point_alu.sv @@
`timescale 1ns / 1ps

module tb_q16_16_fixed_point_alu;
  import q16a_pkg::*;

  localparam logic [2:0] MODE_RSVD5 = 3'd5;
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;
  localparam logic [WORD_W-1:0] FIX_ONE = 32'h0001_0000;
  localparam logic [WORD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam int RANDOM_ITEMS = 1375;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [2:0] in_mode;
  logic signed [WORD_W-1:0] in_operand_a;
  logic signed [WORD_W-1:0] in_operand_b;
  logic out_valid;
  logic out_stall;
  logic signed [WORD_W-1:0] out_result;

  int error_count;
  int pending_count;
  int checked_count;
  int cycle_count;
  int no_gap_left;
  int mode_count[8];

  q16_16_fixed_point_alu dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_mode      (in_mode),
    .in_operand_a (in_operand_a),
    .in_operand_b (in_operand_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_result   (out_result)
  );

  q16a_result_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_operand_a  (in_operand_a),
    .in_operand_b  (in_operand_b),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_result    (out_result),
    .error_count   (error_count),
    .pending_count (pending_count),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // The result side mixes short stalls, long stalls and long stretches with no stall.
  initial begin
    int run;
    int pick;
    run = 0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (run == 0) begin
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
          out_stall <= 1'b0;
          run = $urandom_range(1, 8);
        end else if (pick < 14) begin
          out_stall <= 1'b0;
          run = $urandom_range(30, 120);
        end else if (pick < 18) begin
          out_stall <= 1'b1;
          run = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          run = $urandom_range(10, 40);
        end
      end
      run = run - 1;
    end
  end

  function automatic int pick_gap();
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    gap = 0;
    if (no_gap_left > 0) begin
      no_gap_left = no_gap_left - 1;
    end else if (pick < 55) begin
      gap = 0;
    end else if (pick < 85) begin
      gap = $urandom_range(1, 3);
    end else if (pick < 95) begin
      gap = $urandom_range(4, 10);
    end else if (pick < 98) begin
      gap = $urandom_range(20, 40);
    end else begin
      no_gap_left = $urandom_range(30, 100);
    end
    return gap;
  endfunction

  function automatic logic [WORD_W-1:0] pick_operand();
    logic [WORD_W-1:0] v;
    case ($urandom_range(0, 11))
      0: v = SAT_MAX;
      1: v = SAT_MIN;
      2: v = '0;
      3: v = ALL_ONES;
      4: v = FIX_ONE;
      5, 6: v = {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
      7: v = {{20{$urandom_range(0, 1) == 1}}, 12'($urandom)};
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [2:0] pick_mode();
    logic [2:0] m;
    if ($urandom_range(0, 9) == 0) begin
      m = 3'($urandom_range(MODE_RSVD5, MODE_RSVD7));
    end else begin
      m = 3'($urandom_range(MODE_ADD, MODE_DIV));
    end
    return m;
  endfunction

  task automatic send_op(input logic [2:0] mode, input logic [WORD_W-1:0] a,
                         input logic [WORD_W-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    mode_count[mode] = mode_count[mode] + 1;
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  initial begin
    no_gap_left = 0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_mode      <= MODE_ADD;
    in_operand_a <= '0;
    in_operand_b <= '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_op(MODE_ADD, SAT_MAX, 32'sd1);
    send_op(MODE_ADD, SAT_MIN, ALL_ONES);
    send_op(MODE_ADD, SAT_MAX, SAT_MIN);
    send_op(MODE_ADD, '0, '0);
    send_op(MODE_SUB, SAT_MIN, 32'sd1);
    send_op(MODE_SUB, SAT_MAX, ALL_ONES);
    send_op(MODE_SUB, '0, SAT_MIN);
    send_op(MODE_MUL_SAT, SAT_MAX, SAT_MAX);
    send_op(MODE_MUL_SAT, SAT_MIN, SAT_MAX);
    send_op(MODE_MUL_SAT, SAT_MIN, SAT_MIN);
    send_op(MODE_MUL_SAT, ALL_ONES, 32'sd1);
    send_op(MODE_MUL_SAT, 32'sh0003_0000, 32'shFFFF_8000);
    send_op(MODE_MUL_WRAP, SAT_MAX, SAT_MAX);
    send_op(MODE_MUL_WRAP, SAT_MIN, SAT_MIN);
    send_op(MODE_MUL_WRAP, ALL_ONES, 32'sd1);
    send_op(MODE_DIV, FIX_ONE, '0);
    send_op(MODE_DIV, SAT_MIN, '0);
    send_op(MODE_DIV, SAT_MIN, ALL_ONES);
    send_op(MODE_DIV, SAT_MAX, 32'sd1);
    send_op(MODE_DIV, -32'sd7, 32'sh0002_0000);
    send_op(MODE_DIV, SAT_MIN, SAT_MAX);
    send_op(MODE_DIV, '0, SAT_MIN);
    send_op(MODE_RSVD5, SAT_MAX, SAT_MAX);
    send_op(MODE_RSVD6, FIX_ONE, ALL_ONES);
    send_op(MODE_RSVD7, SAT_MIN, SAT_MIN);
    wait_for_drain();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) begin
        wait_for_drain();
      end
      send_op(pick_mode(), pick_operand(), pick_operand());
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent add %0d, sub %0d, sat mul %0d, wrap mul %0d, divide %0d, unused %0d.",
             mode_count[MODE_ADD], mode_count[MODE_SUB], mode_count[MODE_MUL_SAT],
             mode_count[MODE_MUL_WRAP], mode_count[MODE_DIV],
             mode_count[MODE_RSVD5] + mode_count[MODE_RSVD6] + mode_count[MODE_RSVD7]);
    $display("Compared %0d results under random stalls on both sides.", checked_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
